[hw/rtl/fqs_pkg.sv]
// fqs_pkg: shared constants, codes and controller/datapath bundles for the
// search queue. Depends on nothing; used by fqs_ctrl, fqs_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none

package fqs_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // fixed port widths
    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;
    localparam int POS_W    = 4;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // how the datapath closes a request
    typedef enum logic [2:0] {
        RESP_NONE,
        RESP_NOP,
        RESP_PUSH,
        RESP_FULL,
        RESP_EMPTY,
        RESP_POP,
        RESP_HIT,
        RESP_MISS
    } resp_t;

    typedef struct packed {
        logic  load;
        logic  rd_head;
        logic  rd_scan;
        logic  scan_clr;
        resp_t resp;
    } ctl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             empty;
        logic             full;
        logic             match;
        logic             scan_last;
    } dp_stat_t;

    function automatic logic [ADDR_W-1:0] ring_add(
        input logic [ADDR_W-1:0] base,
        input logic [ADDR_W-1:0] off
    );
        logic [ADDR_W:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= (ADDR_W + 1)'(DEPTH))
        begin
            s = s - (ADDR_W + 1)'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/fifo_queue_with_search_core.sv]
// fifo_queue_with_search_core: top level of the search queue, joining the
// sequencer and the datapath. Depends on fqs_pkg, fqs_ctrl, fqs_dp, fqs_ram.
//
//  channel   handshake        payload                                      width
//  request   start / busy     cmd, value                                   2, 32
//  result    done (strobe)    status, pop_value, fill_count, found,        2, 32, 5,
//                             found_position                                1, 4
//
// push, refused push, empty pop, unused code: busy only for the decode state after acceptance
// pop: busy through decode and the pop wait state (one registered read of the entry ram)
// search: busy through decode and the walk, which ends on a hit at position p or, for a miss,
// after all count entries; one ram read per entry sets the walk
// done pulses for one cycle, the first cycle with busy low; a new request can be
// taken in that same cycle. reset clears head, count, done and controller state only
`timescale 1ns / 1ps
`default_nettype none

module fifo_queue_with_search_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [fqs_pkg::CMD_W-1:0]           cmd,
    input  wire logic signed [fqs_pkg::VALUE_W-1:0]  value,
    output logic                                     done,
    output logic [fqs_pkg::STATUS_W-1:0]             status,
    output logic signed [fqs_pkg::VALUE_W-1:0]       pop_value,
    output logic [fqs_pkg::FILL_W-1:0]               fill_count,
    output logic                                     found,
    output logic [fqs_pkg::POS_W-1:0]                found_position
);

    fqs_pkg::ctl_cmd_t ctl;
    fqs_pkg::dp_stat_t stat;

    fqs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    fqs_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .value          (value),
        .ctl            (ctl),
        .stat           (stat),
        .done           (done),
        .status         (status),
        .pop_value      (pop_value),
        .fill_count     (fill_count),
        .found          (found),
        .found_position (found_position)
    );

endmodule

`default_nettype wire

[hw/rtl/fqs_ram.sv]
// fqs_ram: generic single-write, single-read memory with registered read data.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/fqs_dp.sv]
// fqs_dp: queue datapath - head and count registers, entry ram, scan index,
// key compare and result registers. Depends on fqs_pkg and fqs_ram.
`timescale 1ns / 1ps
`default_nettype none

module fqs_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [fqs_pkg::CMD_W-1:0]     cmd,
    input  wire logic signed [fqs_pkg::VALUE_W-1:0] value,
    input  wire fqs_pkg::ctl_cmd_t             ctl,
    output fqs_pkg::dp_stat_t                  stat,
    output logic                               done,
    output logic [fqs_pkg::STATUS_W-1:0]       status,
    output logic signed [fqs_pkg::VALUE_W-1:0] pop_value,
    output logic [fqs_pkg::FILL_W-1:0]         fill_count,
    output logic                               found,
    output logic [fqs_pkg::POS_W-1:0]          found_position
);

    localparam int AW = fqs_pkg::ADDR_W;
    localparam int CW = fqs_pkg::CNT_W;
    localparam int DW = fqs_pkg::DATA_WIDTH;

    logic [AW-1:0]             head_reg, head_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic [fqs_pkg::CMD_W-1:0] cmd_reg;
    logic [DW-1:0]             key_reg;

    logic                          done_reg, done_next;
    logic [fqs_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [DW-1:0]                 popv_reg, popv_next;
    logic [CW-1:0]                 fill_reg, fill_next;
    logic                          found_reg, found_next;
    logic [AW-1:0]                 pos_reg, pos_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;
    logic [AW-1:0] idx_inc;

    assign idx_inc   = idx_reg + 1'b1;
    assign ram_we    = (ctl.resp == fqs_pkg::RESP_PUSH);
    assign ram_waddr = fqs_pkg::ring_add(head_reg, count_reg[AW-1:0]);
    assign ram_re    = ctl.rd_head | ctl.rd_scan;
    assign ram_raddr = ctl.rd_scan ? fqs_pkg::ring_add(head_reg, idx_inc) : head_reg;

    fqs_ram #(
        .WIDTH (DW),
        .DEPTH (fqs_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        stat.cmd       = cmd_reg;
        stat.empty     = (count_reg == '0);
        stat.full      = (count_reg == CW'(fqs_pkg::DEPTH));
        stat.match     = (ram_rdata == key_reg);
        stat.scan_last = ((CW'(idx_reg) + 1'b1) == count_reg);
    end

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        popv_next   = popv_reg;
        fill_next   = fill_reg;
        found_next  = found_reg;
        pos_next    = pos_reg;

        if (ctl.scan_clr)
        begin
            idx_next = '0;
        end
        else if (ctl.rd_scan)
        begin
            idx_next = idx_inc;
        end

        if (ctl.resp != fqs_pkg::RESP_NONE)
        begin
            done_next   = 1'b1;
            status_next = fqs_pkg::ST_OK;
            popv_next   = '0;
            fill_next   = count_reg;
            found_next  = 1'b0;
            pos_next    = '0;
        end

        case (ctl.resp)
            fqs_pkg::RESP_PUSH:
            begin
                count_next = count_reg + 1'b1;
                fill_next  = count_reg + 1'b1;
            end
            fqs_pkg::RESP_FULL:
            begin
                status_next = fqs_pkg::ST_FULL;
            end
            fqs_pkg::RESP_EMPTY:
            begin
                status_next = fqs_pkg::ST_EMPTY;
            end
            fqs_pkg::RESP_POP:
            begin
                popv_next  = ram_rdata;
                head_next  = fqs_pkg::ring_add(head_reg, AW'(1));
                count_next = count_reg - 1'b1;
                fill_next  = count_reg - 1'b1;
            end
            fqs_pkg::RESP_HIT:
            begin
                found_next = 1'b1;
                pos_next   = idx_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // request latch, scan index and result payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
            key_reg <= value[DW-1:0];
        end
        idx_reg    <= idx_next;
        status_reg <= status_next;
        popv_reg   <= popv_next;
        fill_reg   <= fill_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign pop_value      = fqs_pkg::VALUE_W'(popv_reg);
    assign fill_count     = fqs_pkg::FILL_W'(fill_reg);
    assign found          = found_reg;
    assign found_position = fqs_pkg::POS_W'(pos_reg);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(fqs_pkg::DEPTH))
        else $error("entry count beyond depth");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !stat.full)
        else $error("write into a full queue");

    a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.resp != fqs_pkg::RESP_NONE) |=> done_reg)
        else $error("closed request gave no result strobe");
`endif

endmodule

`default_nettype wire

[hw/rtl/fqs_ctrl.sv]
// fqs_ctrl: request sequencer for the search queue - accepts a request,
// drives the datapath through pop reads and the search walk. Depends on fqs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fqs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire fqs_pkg::dp_stat_t stat,
    output fqs_pkg::ctl_cmd_t      ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_SEARCH
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    always_comb
    begin
        state_next   = state_reg;
        ctl.load     = 1'b0;
        ctl.rd_head  = 1'b0;
        ctl.rd_scan  = 1'b0;
        ctl.scan_clr = 1'b0;
        ctl.resp     = fqs_pkg::RESP_NONE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !busy_reg)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                unique case (stat.cmd)
                    fqs_pkg::CMD_PUSH:
                    begin
                        ctl.resp = stat.full ? fqs_pkg::RESP_FULL : fqs_pkg::RESP_PUSH;
                    end
                    fqs_pkg::CMD_POP:
                    begin
                        if (stat.empty)
                        begin
                            ctl.resp = fqs_pkg::RESP_EMPTY;
                        end
                        else
                        begin
                            ctl.rd_head = 1'b1;
                            state_next  = S_POP_WAIT;
                        end
                    end
                    fqs_pkg::CMD_SEARCH:
                    begin
                        if (stat.empty)
                        begin
                            ctl.resp = fqs_pkg::RESP_MISS;
                        end
                        else
                        begin
                            ctl.rd_head  = 1'b1;
                            ctl.scan_clr = 1'b1;
                            state_next   = S_SEARCH;
                        end
                    end
                    default:
                    begin
                        ctl.resp = fqs_pkg::RESP_NOP;
                    end
                endcase
            end
            S_POP_WAIT:
            begin
                ctl.resp   = fqs_pkg::RESP_POP;
                state_next = S_IDLE;
            end
            S_SEARCH:
            begin
                // read data belongs to the current scan index
                if (stat.match)
                begin
                    ctl.resp   = fqs_pkg::RESP_HIT;
                    state_next = S_IDLE;
                end
                else if (stat.scan_last)
                begin
                    ctl.resp   = fqs_pkg::RESP_MISS;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.rd_scan = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

`ifndef SYNTHESIS
    a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg != S_IDLE))
        else $error("busy flag out of step with state");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> (state_reg == S_EXEC))
        else $error("accepted request did not reach decode");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd_scan |-> (!stat.scan_last && !stat.match))
        else $error("search walked past the last entry");
`endif

endmodule

`default_nettype wire
